[hdl/tog_pkg.sv]
// Shared types and constants for the text overlay glyph renderer.
package tog_pkg;

    localparam int GLYPH_W       = 5;
    localparam int GLYPH_H       = 7;
    localparam int NUM_GLYPHS    = 13;
    localparam int GLYPH_SPACING = 1;
    localparam int BOX_PADDING   = 1;
    localparam int FRAME_WIDTH   = 1920;
    localparam int FRAME_HEIGHT  = 1080;
    localparam int PITCH         = GLYPH_W + GLYPH_SPACING;

    localparam int COORD_W = 12;
    localparam int DELTA_W = COORD_W + 1;
    localparam int COLOR_W = 32;
    localparam int LEN_W   = 5;
    localparam int CODE_W  = 4;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_TEXT_CODES  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_TEXT_LENGTH = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ORIGIN_X    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_ORIGIN_Y    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_FG_COLOR    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_BG_COLOR    = 3'd5;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic [GLYPH_W-1:0] glyph_row_t;

    // rows top to bottom, bit 4 is the leftmost column
    localparam glyph_row_t FONT_ROM [0:NUM_GLYPHS-1][0:GLYPH_H-1] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}
    };

endpackage

[hdl/text_overlay_glyph_renderer_unit.sv]
// Top level of the text overlay glyph renderer: three-stage pixel pipeline.
// Each pixel passes through the stage 1, 2 and 3 registers; m_valid is the stage 3 valid,
//   and an output stall holds the result there until m_ready is high.
// Throughput: one pixel per cycle; each stage refills in the same cycle it drains, and
// s_ready falls only while all three stages are full and m_ready is low.
// Reset (aresetn low, synchronous) empties the pipeline and restores registers:
// text off, origin zero, foreground all ones, background zero.
module text_overlay_glyph_renderer_unit #(
    parameter int MAX_CHARS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [tog_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [tog_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [11:0]              s_pixel_x,
    input  logic [11:0]              s_pixel_y,
    input  logic [31:0]              s_pixel_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [31:0]              m_pixel_out
);
    import tog_pkg::*;

    localparam int CI_W      = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int TEXT_SPAN = MAX_CHARS * PITCH;
    localparam int DXL_W     = $clog2(TEXT_SPAN);
    localparam int CODES_W   = MAX_CHARS * CODE_W;

    // configuration registers
    logic [CODES_W-1:0] text_codes_reg;
    logic [LEN_W-1:0]   text_length_reg;
    coord_t             origin_x_reg;
    coord_t             origin_y_reg;
    color_t             fg_color_reg;
    color_t             bg_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_codes_reg  <= '0;
            text_length_reg <= '0;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            fg_color_reg    <= '1;
            bg_color_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TEXT_CODES:  text_codes_reg  <= cfg_wdata[CODES_W-1:0];
                REG_TEXT_LENGTH: text_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata[COORD_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata[COORD_W-1:0];
                REG_FG_COLOR:    fg_color_reg    <= cfg_wdata[COLOR_W-1:0];
                REG_BG_COLOR:    bg_color_reg    <= cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp length to the stored character count
    logic [LEN_W-1:0] n_eff;
    delta_t           text_right;
    delta_t           box_right;
    assign n_eff      = (text_length_reg > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS)
                                                              : text_length_reg;
    assign text_right = DELTA_W'(n_eff * PITCH);
    assign box_right  = text_right - DELTA_W'(GLYPH_SPACING) + DELTA_W'(BOX_PADDING);

    // per-stage handshake
    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    // stage 1: offsets from origin, frame and enable check
    logic   act1_reg, act1_next;
    delta_t dx1_reg, dx1_next;
    delta_t dy1_reg, dy1_next;
    color_t pix1_reg;

    always_comb begin
        act1_next = ({1'b0, s_pixel_x} < DELTA_W'(FRAME_WIDTH)) &&
                    ({1'b0, s_pixel_y} < DELTA_W'(FRAME_HEIGHT)) &&
                    (n_eff != '0);
        dx1_next  = $signed({1'b0, s_pixel_x}) - $signed({1'b0, origin_x_reg});
        dy1_next  = $signed({1'b0, s_pixel_y}) - $signed({1'b0, origin_y_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            act1_reg <= act1_next;
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            pix1_reg <= s_pixel_in;
        end
    end

    // stage 2: box test, glyph band test, character index
    logic             act2_reg;
    logic             box2_reg, box2_next;
    logic             gok2_reg, gok2_next;
    logic [CI_W-1:0]  ci2_reg, ci2_next;
    logic [DXL_W-1:0] dxl2_reg, dxl2_next;
    logic [2:0]       row2_reg, row2_next;
    color_t           pix2_reg;

    always_comb begin
        box2_next = (bg_color_reg != '0) &&
                    (dx1_reg >= -DELTA_W'(BOX_PADDING)) && (dx1_reg < box_right) &&
                    (dy1_reg >= -DELTA_W'(BOX_PADDING)) &&
                    (dy1_reg < DELTA_W'(GLYPH_H + BOX_PADDING));
        gok2_next = (dx1_reg >= 0) && (dx1_reg < text_right) &&
                    (dy1_reg >= 0) && (dy1_reg < DELTA_W'(GLYPH_H));
        dxl2_next = gok2_next ? dx1_reg[DXL_W-1:0] : '0;
        row2_next = gok2_next ? dy1_reg[2:0] : 3'd0;
        ci2_next  = '0;
        for (int k = 1; k < MAX_CHARS; k++) begin
            if (dxl2_next >= DXL_W'(k * PITCH)) ci2_next = CI_W'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            act2_reg <= act1_reg;
            box2_reg <= box2_next;
            gok2_reg <= gok2_next;
            ci2_reg  <= ci2_next;
            dxl2_reg <= dxl2_next;
            row2_reg <= row2_next;
            pix2_reg <= pix1_reg;
        end
    end

    // stage 3: column within the cell, font lookup, color select
    logic [DXL_W-1:0]  col_full;
    logic [2:0]        col;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] code_idx;
    glyph_row_t        row_bits;
    logic              glyph_hit;
    color_t            pix3_reg, pix3_next;

    always_comb begin
        col_full  = dxl2_reg - DXL_W'(ci2_reg * PITCH);
        col       = col_full[2:0];
        code      = text_codes_reg[ci2_reg * CODE_W +: CODE_W];
        code_idx  = (code < CODE_W'(NUM_GLYPHS)) ? code : '0;
        row_bits  = FONT_ROM[code_idx][row2_reg];
        glyph_hit = gok2_reg && (code < CODE_W'(NUM_GLYPHS)) &&
                    (col < 3'(GLYPH_W)) && row_bits[3'(GLYPH_W - 1) - col];
        if (act2_reg && glyph_hit) begin
            pix3_next = fg_color_reg;
        end else if (act2_reg && box2_reg) begin
            pix3_next = bg_color_reg;
        end else begin
            pix3_next = pix2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            pix3_reg <= pix3_next;
        end
    end

    assign m_valid     = v3_reg;
    assign m_pixel_out = pix3_reg;

    // a full pipeline is the only reason to refuse a transfer
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a bubble in the pipeline");

    // a stalled middle stage must hold its item
    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !adv2) |=> (v2_reg && $stable(dxl2_reg) && $stable(ci2_reg)
                               && $stable(pix2_reg)))
        else $error("stage 2 item changed while stalled");

    // a pixel in the glyph band always maps to a character in use
    a_char_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && gok2_reg) |-> ({{(LEN_W > CI_W ? LEN_W - CI_W : 0){1'b0}}, ci2_reg}
                                  < n_eff))
        else $error("character index beyond text length");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the text overlay glyph renderer pixel pipeline.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tog_pkg::*;

    localparam int MAX_CHARS = 16;
    localparam int RUN_LIMIT = 200000;
    localparam int IDLE_PCT  = 37;
    localparam int RX_HOLD   = 200;
    localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    // rows top to bottom, bit 4 is the leftmost column
    localparam logic [4:0] digit_font [0:12][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h0E, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}
    };

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t c;
    } pix_item_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    coord_t             s_pixel_x = '0;
    coord_t             s_pixel_y = '0;
    color_t             s_pixel_in = '0;
    logic               m_valid;
    logic               m_ready   = 1'b1;
    color_t             m_pixel_out;

    // overlay settings as the block should hold them
    logic [63:0] osd_codes = '0;
    logic [4:0]  osd_len   = '0;
    coord_t      osd_ox    = '0;
    coord_t      osd_oy    = '0;
    color_t      osd_fg    = '1;
    color_t      osd_bg    = '0;

    pix_item_t pixel_queue[$];
    color_t    expected_pixels[$];
    pix_item_t next_pixel;
    color_t    want_pixel;
    int        sent_cnt  = 0;
    int        rx_cnt    = 0;
    int        hold_left = 0;
    int        fail_cnt  = 0;
    int        cycles    = 0;

    text_overlay_glyph_renderer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel_x   (s_pixel_x),
        .s_pixel_y   (s_pixel_y),
        .s_pixel_in  (s_pixel_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out)
    );

    always #5 aclk = ~aclk;

    function automatic color_t overlay_pixel(coord_t px, coord_t py, color_t pin);
        int n, dx, dy, tw, ci, col;
        logic [3:0] code;
        color_t c;
        c = pin;
        n = (osd_len > MAX_CHARS) ? MAX_CHARS : int'(osd_len);
        if (n > 0 && px < FRAME_WIDTH && py < FRAME_HEIGHT) begin
            dx = int'(px) - int'(osd_ox);
            dy = int'(py) - int'(osd_oy);
            if (osd_bg != '0) begin
                tw = n * GLYPH_W + (n - 1) * GLYPH_SPACING;
                if (dx >= -BOX_PADDING && dx < tw + BOX_PADDING &&
                    dy >= -BOX_PADDING && dy < GLYPH_H + BOX_PADDING)
                    c = osd_bg;
            end
            if (dx >= 0 && dy >= 0 && dy < GLYPH_H) begin
                ci  = dx / PITCH;
                col = dx % PITCH;
                if (ci < n && col < GLYPH_W) begin
                    code = osd_codes[4*ci +: 4];
                    // unknown codes still take a pen position but light nothing
                    if (code < NUM_GLYPHS && digit_font[code][dy][GLYPH_W-1-col])
                        c = osd_fg;
                end
            end
        end
        return c;
    endfunction

    // sender: hold payload while stalled, otherwise pull the next pixel or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pixels.push_back(overlay_pixel(s_pixel_x, s_pixel_y, s_pixel_in));
                sent_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() != 0 &&
                    ((sent_cnt >= 700 && sent_cnt < 1000) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    next_pixel = pixel_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_pixel_x  <= next_pixel.x;
                    s_pixel_y  <= next_pixel.y;
                    s_pixel_in <= next_pixel.c;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each transfer, stall at random, hold off twice for a long stretch
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel_out: expected nothing, actual %h", m_pixel_out);
                    fail_cnt++;
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (m_pixel_out !== want_pixel) begin
                        $error("pixel_out: expected %h, actual %h", want_pixel, m_pixel_out);
                        fail_cnt++;
                    end
                end
                rx_cnt++;
                if (rx_cnt == 300 || rx_cnt == 1200)
                    hold_left = RX_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (rx_cnt >= 700 && rx_cnt < 1000) ||
                           ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic push_pixel(int x, int y, color_t c);
        pix_item_t it;
        it.x = coord_t'(x);
        it.y = coord_t'(y);
        it.c = c;
        pixel_queue.push_back(it);
    endtask

    // sample at the falling edge so the sender's last pull is already visible
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || expected_pixels.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_TEXT_CODES:  osd_codes = data;
            REG_TEXT_LENGTH: osd_len   = data[LEN_W-1:0];
            REG_ORIGIN_X:    osd_ox    = data[COORD_W-1:0];
            REG_ORIGIN_Y:    osd_oy    = data[COORD_W-1:0];
            REG_FG_COLOR:    osd_fg    = data[COLOR_W-1:0];
            REG_BG_COLOR:    osd_bg    = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // upper bits of narrow registers carry junk that must be dropped
    task automatic set_overlay(logic [63:0] codes, int len, int ox, int oy,
                               color_t fg, color_t bg);
        logic [CFG_W-1:0] junk;
        wait_drained();
        junk = {$urandom, $urandom};
        cfg_write(REG_TEXT_CODES, codes);
        cfg_write(REG_TEXT_LENGTH, {junk[63:LEN_W], LEN_W'(len)});
        cfg_write(REG_ORIGIN_X, {junk[63:COORD_W], COORD_W'(ox)});
        cfg_write(REG_ORIGIN_Y, {junk[63:COORD_W], COORD_W'(oy)});
        cfg_write(REG_FG_COLOR, {junk[63:COLOR_W], fg});
        cfg_write(REG_BG_COLOR, {junk[63:COLOR_W], bg});
        cfg_write(($urandom_range(1) != 0) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int n, tw, r, x, y, len, ox, oy;
        logic [63:0] codes;
        color_t fg, bg;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: overlay off
        push_pixel(0, 0, 32'h0000_0000);
        push_pixel(4095, 0, 32'hFFFF_FFFF);

        // every code once, box on
        set_overlay(64'hFEDC_BA98_7654_3210, 16, 100, 50, 32'hA1B2_C3D4, 32'h1122_3344);
        push_pixel(99, 49, 32'h0000_0000);      // box top-left padding
        push_pixel(194, 57, 32'hFFFF_FFFF);     // box bottom padding row
        push_pixel(195, 57, 32'h5555_5555);     // box bottom-right padding corner
        push_pixel(99, 48, 32'hAAAA_AAAA);      // just above the box
        push_pixel(101, 50, $urandom);          // digit zero, lit
        push_pixel(100, 50, $urandom);          // digit zero, dark
        push_pixel(105, 53, $urandom);          // spacing column
        push_pixel(149, 53, $urandom);          // digit eight middle bar
        push_pixel(161, 53, $urandom);          // dash
        push_pixel(174, 51, $urandom);          // colon dot
        push_pixel(180, 53, $urandom);          // unknown code
        push_pixel(1920, 50, $urandom);         // right of frame
        push_pixel(100, 1080, $urandom);        // below frame
        push_pixel(4095, 4095, 32'hFFFF_FFFF);

        // text hanging off the bottom-right corner
        set_overlay(64'h88, 2, 1915, 1075, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        push_pixel(1919, 1079, $urandom);
        push_pixel(1914, 1074, $urandom);
        push_pixel(1920, 1079, $urandom);

        // length zero turns the box off too
        set_overlay(64'h1234, 0, 10, 10, 32'h0102_0304, 32'h0506_0708);
        push_pixel(10, 10, $urandom);

        for (int p = 0; p < 12; p++) begin
            codes = {$urandom, $urandom};
            len   = $urandom_range(31);
            ox    = $urandom_range(FRAME_WIDTH - 1);
            oy    = $urandom_range(FRAME_HEIGHT - 1);
            fg    = $urandom;
            bg    = ($urandom_range(3) == 0) ? 32'h0 : $urandom;
            case (p)
                0: begin len = 16; ox = 0; oy = 0; bg = bg | 32'h1; end
                1: begin codes = '1; len = 31; ox = 4095; oy = 4095; end
                2: begin codes = '0; len = 17; ox = 1900; oy = 1073; fg = '0; bg = '1; end
                3: begin len = 0; bg = bg | 32'h1; end
                4: begin len = 1; bg = '0; end
                5: begin fg = '1; bg = 32'h0000_0001; end
                default: ;
            endcase
            set_overlay(codes, len, ox, oy, fg, bg);
            n  = (len > MAX_CHARS) ? MAX_CHARS : len;
            tw = (n > 0) ? n * PITCH - GLYPH_SPACING : GLYPH_W;
            for (int i = 0; i < 160; i++) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    x = ox + $urandom_range(tw + 3) - 2;
                    y = oy + $urandom_range(GLYPH_H + 3) - 2;
                end else if (r < 85) begin
                    x = $urandom_range(4095);
                    y = $urandom_range(4095);
                end else begin
                    x = FRAME_WIDTH - 4 + $urandom_range(7);
                    y = FRAME_HEIGHT - 4 + $urandom_range(7);
                end
                push_pixel(x, y, $urandom);
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        while (cycles < RUN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/tog_pkg.sv
hdl/text_overlay_glyph_renderer_unit.sv
verif/tb_top.sv
